// ===== design/mbps_pkg.sv =====
package mbps_pkg;

    // Field widths fixed by the item format
    localparam int ENTRY_W    = 6;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 32;
    localparam int PLEN_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Request type codes on the input channel
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_SCAN    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LENGTH  = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SCAN,
        OP_RESTART
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [ENTRY_W-1:0] idx;
        logic [BYTE_W-1:0]  data;
        logic               care;
        logic               last;
    } qitem_t;

endpackage

// ===== design/mbps_if.sv =====
interface mbps_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [5:0] entry_index;
    logic [7:0] byte_value;
    logic       care;
    logic       last_byte;

    modport source (output valid, req_type, entry_index, byte_value, care, last_byte,
                    input ready);
    modport sink   (input valid, req_type, entry_index, byte_value, care, last_byte,
                    output ready);
endinterface

interface mbps_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;

    modport source (output valid, found, match_offset, input ready);
    modport sink   (input valid, found, match_offset, output ready);
endinterface

// ===== design/mbps_front.sv =====
module mbps_front
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    mbps_req_if.sink    req,
    output logic        push_valid,
    output qitem_t      push_item,
    input  logic        push_ready
);

    logic   stage_valid_reg;
    logic   stage_valid_next;
    qitem_t stage_item_reg;
    qitem_t stage_item_next;
    logic   keep;
    logic   take;

    assign req.ready = !stage_valid_reg || push_ready;
    assign take      = req.valid && req.ready;

    // Decode the request; loads past the store and unused codes are dropped here
    always_comb
    begin
        stage_item_next.idx  = req.entry_index;
        stage_item_next.data = req.byte_value;
        stage_item_next.care = req.care;
        stage_item_next.last = req.last_byte;
        stage_item_next.op   = OP_SCAN;
        keep                 = 1'b0;
        case (req.req_type)
            REQ_LOAD:
            begin
                stage_item_next.op = OP_LOAD;
                keep = (PLEN_W'(req.entry_index) < PLEN_W'(MAX_PATTERN));
            end
            REQ_SCAN:
            begin
                stage_item_next.op = OP_SCAN;
                keep = 1'b1;
            end
            REQ_RESTART:
            begin
                stage_item_next.op = OP_RESTART;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (req.ready)
        begin
            stage_valid_next = take && keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg <= stage_item_next;
        end
    end

    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

endmodule

// ===== design/mbps_queue.sv =====
module mbps_queue
    import mbps_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    input  qitem_t push_item,
    output logic   push_ready,
    output logic   pop_valid,
    output qitem_t pop_item,
    input  logic   pop_ready
);

    qitem_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/mbps_back.sv =====
module mbps_back
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    input  qitem_t                pop_item,
    output logic                  pop_ready,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mbps_res_if.source            res
);

    localparam int TAP_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Pattern cells, each compared in parallel against the scan byte
    logic [BYTE_W-1:0]      pat_reg  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] care_reg;

    logic [MAX_PATTERN-1:0] vec_reg;
    logic [MAX_PATTERN-1:0] vec_next;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;
    logic                   done_reg;
    logic                   done_next;

    // Decoded length settings, refreshed on each pattern_length or search_length write
    logic                   len_zero_reg;
    logic                   len_zero_next;
    logic [PLEN_W-1:0]      lenm1_reg;
    logic [PLEN_W-1:0]      lenm1_next;
    logic [COUNT_W-1:0]     slen_reg;
    logic [COUNT_W-1:0]     slen_next;
    logic [PLEN_W-1:0]      act_len;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   found_reg;
    logic                   found_next;
    logic [COUNT_W-1:0]     offset_reg;
    logic [COUNT_W-1:0]     offset_next;

    logic [MAX_PATTERN-1:0] accept;
    logic [MAX_PATTERN-1:0] shifted;
    logic [MAX_PATTERN-1:0] vec_scan;
    logic                   pop;
    logic                   scan;
    logic                   indexable;
    logic                   hit;
    logic [COUNT_W-1:0]     start;
    logic                   emit;

    assign pop_ready = !out_valid_reg || res.ready;
    assign pop       = pop_valid && pop_ready;
    assign scan      = pop && (pop_item.op == OP_SCAN) && !done_reg;

    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            accept[j] = !care_reg[j] || (pat_reg[j] == pop_item.data);
        end
    end

    assign shifted   = (vec_reg << 1) | MAX_PATTERN'(1);
    assign vec_scan  = shifted & accept;
    assign indexable = (count_reg != '1);
    assign start     = count_reg - COUNT_W'(lenm1_reg);
    assign hit       = !len_zero_reg && indexable && vec_scan[lenm1_reg[TAP_W-1:0]];

    always_comb
    begin
        vec_next       = vec_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        emit           = 1'b0;
        found_next     = found_reg;
        offset_next    = offset_reg;
        if (pop && (pop_item.op == OP_RESTART))
        begin
            vec_next   = '0;
            count_next = '0;
            done_next  = 1'b0;
        end
        else if (scan)
        begin
            vec_next = vec_scan;
            if (indexable)
            begin
                count_next = count_reg + 1'b1;
            end
            if (hit && (start < slen_reg))
            begin
                done_next   = 1'b1;
                emit        = 1'b1;
                found_next  = 1'b1;
                offset_next = start;
            end
            else if (pop_item.last)
            begin
                done_next   = 1'b1;
                emit        = 1'b1;
                found_next  = 1'b0;
                offset_next = '0;
            end
        end
        out_valid_next = emit ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
    end

    // Clamp pattern_length to the store depth
    assign act_len = (cfg_data[PLEN_W-1:0] > PLEN_W'(MAX_PATTERN)) ?
                     PLEN_W'(MAX_PATTERN) : cfg_data[PLEN_W-1:0];

    always_comb
    begin
        len_zero_next = len_zero_reg;
        lenm1_next    = lenm1_reg;
        slen_next     = slen_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH:
                begin
                    len_zero_next = (act_len == '0);
                    lenm1_next    = act_len - 1'b1;
                end
                CFG_SEARCH_LENGTH:
                begin
                    slen_next = cfg_data;
                end
                default:
                begin
                    slen_next = slen_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg       <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            len_zero_reg  <= 1'b0;
            lenm1_reg     <= '0;
            slen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vec_reg       <= vec_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            len_zero_reg  <= len_zero_next;
            lenm1_reg     <= lenm1_next;
            slen_reg      <= slen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        offset_reg <= offset_next;
        if (pop && (pop_item.op == OP_LOAD))
        begin
            pat_reg[pop_item.idx[TAP_W-1:0]]  <= pop_item.data;
            care_reg[pop_item.idx[TAP_W-1:0]] <= pop_item.care;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.found        = found_reg;
    assign res.match_offset = offset_reg;

    // A full match needs at least pattern_length bytes since restart
    a_hit_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        scan && hit |-> count_reg >= COUNT_W'(lenm1_reg))
        else $error("match tap set before enough bytes");

    // Search stays finished until a restart is executed
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !(pop && pop_item.op == OP_RESTART) |=> done_reg)
        else $error("search_done dropped without restart");

    // Every new result comes with search_done set
    a_emit_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> done_reg && out_valid_reg)
        else $error("result issued without finishing the search");

    // A not-found result carries a zero offset
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> offset_reg == '0)
        else $error("not-found result with nonzero offset");

endmodule

// ===== design/masked_byte_pattern_search_top.sv =====
// Masked byte pattern search.
// Channels: req (sink) carries load, scan and restart requests; res (source)
// carries at most one result per search: found and match_offset. Both use a
// valid/ready handshake; a transfer happens on a clock edge with both high.
// Config: cfg_we/cfg_index/cfg_data write pattern_length (index 0) or
// search_length (index 1); write only while the block is idle.
// Throughput: one request per cycle while res takes its results. The front
// stage registers and decodes each request, a 4-entry queue decouples it from
// the back stage, and the back stage compares the scan byte against all
// pattern cells at once. A result travels from the transfer of the scan byte
// that causes it through the front register, a queue slot and the back stage
// into the result register.
// A stalled res holds the result and the back stage stops taking requests
// until it is transferred; the queue then fills, and req.ready drops only
// once the front register and the queue are full.
// Reset: match state, byte count, done flag and the queue clear at once;
// pattern_length resets to 1, search_length to 0. Pattern cells are not
// cleared and must be loaded before they are compared.
module masked_byte_pattern_search_top
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    mbps_req_if.sink              req,
    mbps_res_if.source            res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // front -> queue
    logic   f_valid;
    qitem_t f_item;
    logic   f_ready;

    // queue -> back
    logic   b_valid;
    qitem_t b_item;
    logic   b_ready;

    mbps_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (f_valid),
        .push_item  (f_item),
        .push_ready (f_ready)
    );

    // Decoupling queue: lets the back stall on a full result register
    mbps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_item  (f_item),
        .push_ready (f_ready),
        .pop_valid  (b_valid),
        .pop_item   (b_item),
        .pop_ready  (b_ready)
    );

    // Shift-and match engine with pattern cells and result register
    mbps_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (b_valid),
        .pop_item  (b_item),
        .pop_ready (b_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

endmodule

// ===== tb/sv/masked_byte_pattern_search_top_test.sv =====
module masked_byte_pattern_search_top_test;
    import mbps_pkg::*;

    localparam int PAT_DEPTH    = 64;      // matches the block's default MAX_PATTERN
    localparam int ITEM_BUDGET  = 1200;    // requests that do real work in the random part
    localparam int IDLE_PCT     = 28;
    localparam int SETTLE_LAT   = 12;      // front reg + 4-deep queue + back stage, with slack
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;
    // The limit leaves room for the slowest correct run (about 1400 requests,
    // random gaps on both sides, one long result hold, a settle pause per phase).
    localparam int LIMIT_CYCLES = 400000;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam bit [BYTE_W-1:0] MARK_BYTE = "X";

    typedef struct packed {
        logic [1:0]         op;
        logic [ENTRY_W-1:0] idx;
        logic [BYTE_W-1:0]  value;
        logic               care;
        logic               last;
    } req_item_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] offset;
    } search_result_t;

    typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

    // One line of the directed table: either a request or a register write.
    // Rows with typed set carry their expected result written out by hand.
    typedef struct {
        row_kind_t              kind;
        req_item_t              item;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        bit                     typed;
        bit                     exp_has;
        search_result_t         exp;
    } test_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mbps_req_if req_ch();
    mbps_res_if res_ch();

    masked_byte_pattern_search_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the search state, updated at every request transfer.
    bit [BYTE_W-1:0]    pat_bytes [PAT_DEPTH];
    bit                 pat_care  [PAT_DEPTH];
    bit [PAT_DEPTH-1:0] match_vec;
    bit [COUNT_W-1:0]   scanned;
    bit                 search_over;
    bit [PLEN_W-1:0]    cur_plen;
    bit [COUNT_W-1:0]   cur_slen;

    search_result_t expected_results [$];

    int  acted_items;      // requests that changed state (ignored ones excluded)
    int  sent_items;
    int  results_seen;
    int  matches_seen;
    int  mismatches;
    int  cycle_count;
    bit  res_hold;
    logic calm;

    // No idling on either side for a stretch in the middle of the run.
    assign calm = (acted_items >= 500) && (acted_items < 700);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH (cycle %0d, result %0d): %s", cycle_count, results_seen, what);
        mismatches++;
    endtask

    function automatic req_item_t make_req(input logic [1:0] op,
                                           input logic [ENTRY_W-1:0] idx,
                                           input logic [BYTE_W-1:0] value,
                                           input logic care,
                                           input logic last);
        req_item_t it;
        it.op    = op;
        it.idx   = idx;
        it.value = value;
        it.care  = care;
        it.last  = last;
        return it;
    endfunction

    // Shift-and update for one request. Bit j of match_vec says the last j+1
    // scan bytes match pattern positions 0..j; a hit on bit len-1 is a full match.
    function automatic void predict_search(input req_item_t it, output bit has,
                                           output search_result_t res, output bit acted);
        bit [PAT_DEPTH-1:0] accept;
        bit [COUNT_W-1:0]   pos;
        bit [COUNT_W-1:0]   start;
        bit                 at_top;
        int                 eff_len;
        has   = 1'b0;
        res   = '0;
        acted = 1'b1;
        case (it.op)
            REQ_LOAD:
            begin
                pat_bytes[it.idx] = it.value;
                pat_care[it.idx]  = it.care;
            end
            REQ_RESTART:
            begin
                match_vec   = '0;
                scanned     = '0;
                search_over = 1'b0;
            end
            REQ_SCAN:
            begin
                if (search_over)
                begin
                    acted = 1'b0;
                end
                else
                begin
                    for (int j = 0; j < PAT_DEPTH; j++)
                        accept[j] = !pat_care[j] || (pat_bytes[j] == it.value);
                    pos       = scanned;
                    at_top    = (pos == '1);       // count saturates, no match past it
                    match_vec = ((match_vec << 1) | 1) & accept;
                    if (!at_top)
                        scanned = pos + 1;
                    eff_len = (cur_plen > PAT_DEPTH) ? PAT_DEPTH : int'(cur_plen);
                    if (eff_len > 0 && !at_top && match_vec[eff_len-1])
                    begin
                        start = pos - COUNT_W'(eff_len - 1);
                        // a match starting at or past search_length is dropped
                        if (start < cur_slen)
                        begin
                            search_over = 1'b1;
                            has         = 1'b1;
                            res.found   = 1'b1;
                            res.offset  = start;
                        end
                    end
                    if (!has && it.last)
                    begin
                        search_over = 1'b1;
                        has         = 1'b1;
                    end
                end
            end
            default:
            begin
                acted = 1'b0;              // unused request type
            end
        endcase
    endfunction

    // Offer one request, hold it until the transfer, then book its expected result.
    task automatic send_req(input req_item_t it, input bit typed, input bit typed_has,
                            input search_result_t typed_res);
        bit             has;
        bit             acted;
        search_result_t res;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= it.op;
        req_ch.entry_index <= it.idx;
        req_ch.byte_value  <= it.value;
        req_ch.care        <= it.care;
        req_ch.last_byte   <= it.last;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predict_search(it, has, res, acted);
        if (typed)
        begin
            has = typed_has;
            res = typed_res;
        end
        if (has)
            expected_results.push_back(res);
        if (acted)
            acted_items++;
        sent_items++;
    endtask

    // Registers may only change with nothing in flight. Loads and scans that
    // give no result can still sit in the queue, so wait out a settle pause too.
    task automatic wait_until_idle();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_LAT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_PATTERN_LENGTH)
            cur_plen = data[PLEN_W-1:0];
        else
            cur_slen = data;
    endtask

    // One search: load a pattern over a small alphabet, usually restart, then
    // stream a region that usually carries a planted copy of the pattern. Stray
    // loads, unused requests and restarts are mixed in as noise.
    task automatic run_search_region();
        bit [BYTE_W-1:0] alphabet [4];
        bit [BYTE_W-1:0] word [PAT_DEPTH];
        bit              word_care [PAT_DEPTH];
        bit [BYTE_W-1:0] b;
        int              eff_len;
        int              load_len;
        int              region_len;
        int              plant_at;
        int              roll;
        bit              planted;
        bit              last;
        for (int k = 0; k < 4; k++)
            alphabet[k] = BYTE_W'($urandom_range(255));
        eff_len  = (cur_plen > PAT_DEPTH) ? PAT_DEPTH : int'(cur_plen);
        load_len = (eff_len == 0) ? $urandom_range(1, 4) : eff_len;
        for (int j = 0; j < load_len; j++)
        begin
            word[j]      = alphabet[$urandom_range(3)];
            word_care[j] = ($urandom_range(99) < 75);
            send_req(make_req(REQ_LOAD, ENTRY_W'(j), word[j], word_care[j],
                              1'($urandom_range(1))), 1'b0, 1'b0, '0);
        end
        if ($urandom_range(99) < 92)
            send_req(make_req(REQ_RESTART, ENTRY_W'($urandom_range(63)),
                              BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1))), 1'b0, 1'b0, '0);
        region_len = load_len + $urandom_range(0, (load_len > 16) ? 24 : 30);
        planted    = ($urandom_range(99) < 75);
        plant_at   = $urandom_range(0, region_len - load_len);
        for (int i = 0; i < region_len; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                send_req(make_req(REQ_LOAD, ENTRY_W'($urandom_range(63)),
                                  BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                                  1'($urandom_range(1))), 1'b0, 1'b0, '0);
            else if (roll < 5)
                send_req(make_req(REQ_UNUSED, ENTRY_W'($urandom_range(63)),
                                  BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                                  1'($urandom_range(1))), 1'b0, 1'b0, '0);
            else if (roll == 5)
                send_req(make_req(REQ_RESTART, '0, '0, 1'b0, 1'b0), 1'b0, 1'b0, '0);
            if (planted && i >= plant_at && i < plant_at + load_len && word_care[i-plant_at])
                b = word[i-plant_at];
            else if ($urandom_range(9) == 0)
                b = BYTE_W'($urandom_range(255));
            else
                b = alphabet[$urandom_range(3)];
            last = (i == region_len - 1) && ($urandom_range(99) < 95);
            send_req(make_req(REQ_SCAN, ENTRY_W'($urandom_range(63)), b,
                              1'($urandom_range(1)), last), 1'b0, 1'b0, '0);
            // once done, further scans are ignored; keep only a few of them
            if (search_over && $urandom_range(99) < 70)
                break;
        end
    endtask

    // Result side: random stalls, a quiet stretch, and the long hold below.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_hold)
                res_ch.ready <= 1'b0;
            else if (calm)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Long hold on the result channel while requests keep coming: the held
    // result blocks the back stage, the queue fills, and req.ready must drop.
    initial
    begin
        res_hold = 1'b0;
        wait (acted_items >= 900);
        @(posedge clk);
        res_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_hold <= 1'b0;
    end

    // Result checker: every transfer on res against the oldest expectation.
    initial
    begin
        search_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                results_seen++;
                if (res_ch.found === 1'b1)
                    matches_seen++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result found=%0b offset=%0d",
                                              res_ch.found, res_ch.match_offset));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_ch.found !== want.found)
                        report_mismatch($sformatf("found=%0b, expected %0b",
                                                  res_ch.found, want.found));
                    if (res_ch.match_offset !== want.offset)
                        report_mismatch($sformatf("match_offset=%0d, expected %0d",
                                                  res_ch.match_offset, want.offset));
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_count, expected_results.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        test_row_t       dir_rows [$];
        test_row_t       row;
        int unsigned     plen_plan [10];
        int unsigned     slen_plan [10];
        int              phase;
        int              phase_start;
        int              drain;
        int              directed_items;
        bit [PLEN_W-1:0] plen_pick;
        bit [COUNT_W-1:0] slen_pick;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_LOAD;
        req_ch.entry_index = '0;
        req_ch.byte_value  = '0;
        req_ch.care        = 1'b0;
        req_ch.last_byte   = 1'b0;
        match_vec          = '0;
        scanned            = '0;
        search_over        = 1'b0;
        cur_plen           = 1;      // register reset values
        cur_slen           = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pattern cells come out of reset undefined: fill every one as a wildcard
        // so nothing unwritten is ever compared.
        for (int j = 0; j < PAT_DEPTH; j++)
            send_req(make_req(REQ_LOAD, ENTRY_W'(j), BYTE_W'($urandom_range(255)), 1'b0, 1'b0),
                     1'b0, 1'b0, '0);

        // Directed table. Typed rows give the exact outcome; the rest are checked
        // against the mirror.
        row = '{kind: ROW_REQ, item: '0, reg_idx: '0, reg_val: '0, typed: 1'b1,
                exp_has: 1'b0, exp: '0};
        // search_length is 0 after reset: the match at offset 0 is dropped
        row.item = make_req(REQ_SCAN, '0, 8'h41, 1'b0, 1'b1);
        row.exp_has = 1'b1; row.exp = '{found: 1'b0, offset: '0};
        dir_rows.push_back(row);
        // scan after done is ignored
        row.item = make_req(REQ_SCAN, '0, 8'h42, 1'b0, 1'b1);
        row.exp_has = 1'b0;
        dir_rows.push_back(row);
        row.kind = ROW_CFG; row.reg_idx = CFG_SEARCH_LENGTH; row.reg_val = 32'hFFFF_FFFF;
        dir_rows.push_back(row);
        row.kind = ROW_REQ;
        row.item = make_req(REQ_RESTART, '0, '0, 1'b0, 1'b0);
        dir_rows.push_back(row);
        row.item = make_req(REQ_LOAD, '0, MARK_BYTE, 1'b1, 1'b0);
        dir_rows.push_back(row);
        row.item = make_req(REQ_LOAD, 6'd63, 8'hFF, 1'b0, 1'b1);
        dir_rows.push_back(row);
        row.item = make_req(REQ_SCAN, '0, 8'h00, 1'b0, 1'b0);
        dir_rows.push_back(row);
        row.item = make_req(REQ_SCAN, '0, MARK_BYTE, 1'b0, 1'b0);
        row.exp_has = 1'b1; row.exp = '{found: 1'b1, offset: 32'd1};
        dir_rows.push_back(row);
        // last byte after a match: still ignored
        row.item = make_req(REQ_SCAN, '0, MARK_BYTE, 1'b0, 1'b1);
        row.exp_has = 1'b0;
        dir_rows.push_back(row);
        row.item = make_req(REQ_RESTART, '0, '0, 1'b0, 1'b0);
        dir_rows.push_back(row);
        // zero pattern length never matches, last byte still reports
        row.kind = ROW_CFG; row.reg_idx = CFG_PATTERN_LENGTH; row.reg_val = 32'd0;
        dir_rows.push_back(row);
        row.kind = ROW_REQ;
        row.item = make_req(REQ_SCAN, '0, MARK_BYTE, 1'b0, 1'b1);
        row.exp_has = 1'b1; row.exp = '{found: 1'b0, offset: '0};
        dir_rows.push_back(row);
        row.item = make_req(REQ_RESTART, '0, '0, 1'b0, 1'b0);
        row.exp_has = 1'b0;
        dir_rows.push_back(row);
        // unused request type with every field at its top
        row.item = make_req(REQ_UNUSED, 6'd63, 8'hFF, 1'b1, 1'b1);
        dir_rows.push_back(row);
        // length above the maximum clamps to 64: one byte cannot match
        row.kind = ROW_CFG; row.reg_idx = CFG_PATTERN_LENGTH; row.reg_val = 32'd127;
        dir_rows.push_back(row);
        row.kind = ROW_REQ;
        row.item = make_req(REQ_SCAN, '0, 8'hFF, 1'b0, 1'b1);
        row.exp_has = 1'b1; row.exp = '{found: 1'b0, offset: '0};
        dir_rows.push_back(row);
        row.item = make_req(REQ_RESTART, '0, '0, 1'b0, 1'b0);
        row.exp_has = 1'b0;
        dir_rows.push_back(row);
        row.kind = ROW_CFG; row.reg_idx = CFG_PATTERN_LENGTH; row.reg_val = 32'd2;
        dir_rows.push_back(row);
        row.kind = ROW_REQ;
        row.item = make_req(REQ_LOAD, 6'd1, 8'hFF, 1'b1, 1'b0);
        dir_rows.push_back(row);
        row.typed = 1'b0;
        row.item = make_req(REQ_SCAN, '0, MARK_BYTE, 1'b0, 1'b0);
        dir_rows.push_back(row);
        row.typed = 1'b1;
        row.item = make_req(REQ_SCAN, '0, 8'hFF, 1'b0, 1'b0);
        row.exp_has = 1'b1; row.exp = '{found: 1'b1, offset: '0};
        dir_rows.push_back(row);
        row.item = make_req(REQ_RESTART, '0, '0, 1'b0, 1'b0);
        row.exp_has = 1'b0;
        dir_rows.push_back(row);
        // match starting exactly at search_length is dropped
        row.kind = ROW_CFG; row.reg_idx = CFG_SEARCH_LENGTH; row.reg_val = 32'd1;
        dir_rows.push_back(row);
        row.kind = ROW_REQ; row.typed = 1'b0;
        row.item = make_req(REQ_SCAN, '0, 8'h00, 1'b0, 1'b0);
        dir_rows.push_back(row);
        row.item = make_req(REQ_SCAN, '0, MARK_BYTE, 1'b0, 1'b0);
        dir_rows.push_back(row);
        row.item = make_req(REQ_SCAN, '0, 8'hFF, 1'b0, 1'b0);
        dir_rows.push_back(row);
        row.typed = 1'b1;
        row.item = make_req(REQ_SCAN, '0, MARK_BYTE, 1'b0, 1'b1);
        row.exp_has = 1'b1; row.exp = '{found: 1'b0, offset: '0};
        dir_rows.push_back(row);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_until_idle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
            begin
                send_req(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].exp_has,
                         dir_rows[i].exp);
            end
        end
        directed_items = sent_items;

        // Random phases: extremes first, then mostly short patterns.
        plen_plan = '{1, 64, 127, 0, 2, 8, 3, 100, 5, 4};
        slen_plan = '{20, 32'hFFFF_FFFF, 40, 0, 32'hFFFF_FFFF, 4, 1, 32'h8000_0000, 9,
                      32'hFFFF_FFFF};
        acted_items = 0;
        phase = 0;
        while (acted_items < ITEM_BUDGET)
        begin
            if (phase < 10)
            begin
                plen_pick = PLEN_W'(plen_plan[phase]);
                slen_pick = slen_plan[phase];
            end
            else
            begin
                plen_pick = PLEN_W'($urandom_range(1, 10));
                slen_pick = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : $urandom_range(0, 40);
            end
            wait_until_idle();
            // upper data bits beyond the length field are junk and must be ignored
            write_reg(CFG_PATTERN_LENGTH,
                      {(CFG_DATA_W-PLEN_W)'($urandom()), plen_pick});
            write_reg(CFG_SEARCH_LENGTH, slen_pick);
            phase_start = acted_items;
            while (acted_items - phase_start < 140)
                run_search_region();
            phase++;
        end

        req_ch.valid <= 1'b0;
        drain = 0;
        while (expected_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_LAT * 2) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));

        $display("Covered %0d requests (%0d setup and directed) over %0d register settings",
                 sent_items, directed_items, phase + 6);
        $display("Checked %0d results, %0d with a match, %0d mismatches",
                 results_seen, matches_seen, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
